### hdl/appb_pkg.sv
// shared types, constants and helpers for the audio ping-pong buffer
// no dependencies; imported by appb_ram users and the top level
`default_nettype none

package appb_pkg;

   // samples per frame, one frame per buffer half
   localparam int FRAME_SAMPLES = 735;
   localparam int STORE_DEPTH   = 2 * FRAME_SAMPLES;
   localparam int IDX_W         = $clog2(FRAME_SAMPLES);
   localparam int ADDR_W        = $clog2(STORE_DEPTH);
   localparam int SAMPLE_W      = 16;
   localparam int DAC_W         = 9;
   localparam int DAC_SHIFT     = 7;
   localparam int BIAS          = 32'h7fff;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_SAMPLES - 1);

   typedef enum logic {
      REQ_WRITE = 1'b0,
      REQ_TICK  = 1'b1
   } appb_req_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } appb_status_type;

   // side information that is registered alongside the memory read
   typedef struct packed {
      logic            played;
      appb_status_type status;
      logic            frame_done;
   } appb_meta_type;

   // flat store address of a slot in buffer half sel
   function automatic logic [ADDR_W-1:0] slot_addr(input logic sel,
                                                   input logic [IDX_W-1:0] idx);
      logic [ADDR_W-1:0] base;
      base = sel ? ADDR_W'(FRAME_SAMPLES) : '0;
      return base + ADDR_W'(idx);
   endfunction

   // converter code: arithmetic (sample + 0x7fff) >> 7, low bits kept
   function automatic logic [DAC_W-1:0] dac_code(input logic [SAMPLE_W-1:0] raw);
      logic signed [SAMPLE_W:0] sum;
      sum = $signed({raw[SAMPLE_W-1], raw}) + $signed((SAMPLE_W+1)'(BIAS));
      return sum[DAC_SHIFT +: DAC_W];
   endfunction

endpackage

`default_nettype wire

### hdl/appb_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module appb_ram #(
   parameter int WIDTH  = 16,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read data holds while rd_en is low
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hdl/audio_ping_pong_buffer_unit.sv
// audio ping-pong buffer: two frame buffers alternating between fill and play
// depends on appb_pkg and appb_ram
//
// usage
//   req channel: one beat per operation. req_tuser selects a sample write (0)
//     or a converter play tick (1); req_tdata carries the signed sample.
//   rsp channel: exactly one beat per req beat, in order. rsp_tdata holds the
//     converter code, rsp_tuser the played flag and status, rsp_tlast marks
//     the beat that completed filling or playing a frame.
//   writes into a buffer half still waiting to be played are refused with
//     the full status; ticks with no full buffer return the empty status.
// timing
//   a req beat passes two registers on its way to rsp: first the sample store
//   read port, then the result register. one req beat per cycle is taken
//   sustained while rsp_tready stays high; the single read port of the sample store sets that figure.
// reset
//   synchronous; both halves empty, fill and play pointers at half 0 slot 0.
//   store contents are not cleared, a half is only read after it is filled.
// stalls
//   while rsp_tready is low the result register and the beat behind it hold;
//   req_tready drops only once both are occupied.
`default_nettype none

module audio_ping_pong_buffer_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   // request side
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [15:0] sample
   input  wire logic [0:0]  req_tuser,   // [0] req_type
   // result side
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [15:0] rsp_tdata,   // [8:0] dac_value, [15:9] zero
   output logic      [2:0]  rsp_tuser,   // [0] dac_valid, [2:1] status
   output logic             rsp_tlast    // frame_done
);

   import appb_pkg::*;

   // buffer bookkeeping
   logic [1:0]       full_ff,  full_in;
   logic             wsel_ff,  wsel_in;
   logic [IDX_W-1:0] widx_ff,  widx_in;
   logic             psel_ff,  psel_in;
   logic [IDX_W-1:0] pidx_ff,  pidx_in;

   // beat waiting on the store read
   logic          s1_valid_ff, s1_valid_in;
   appb_meta_type s1_meta_ff,  s1_meta_in;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [DAC_W-1:0] rsp_dac_ff,   rsp_dac_in;
   logic             rsp_played_ff;
   appb_status_type  rsp_status_ff;
   logic             rsp_last_ff;

   logic                accept;
   logic                is_tick;
   logic                write_ok;
   logic                play_ok;
   logic                s1_adv;
   logic                ram_wr_en;
   logic                ram_rd_en;
   logic [SAMPLE_W-1:0] ram_rd_data;

   // handshakes: the result register frees as it is taken
   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign accept     = req_tvalid && req_tready;

   assign is_tick  = (appb_req_type'(req_tuser[0]) == REQ_TICK);
   assign write_ok = !full_ff[wsel_ff];
   assign play_ok  = full_ff[psel_ff];

   assign ram_wr_en = accept && !is_tick && write_ok;
   assign ram_rd_en = accept && is_tick && play_ok;

   appb_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (slot_addr(wsel_ff, widx_ff)),
      .wr_data (req_tdata),
      .rd_en   (ram_rd_en),
      .rd_addr (slot_addr(psel_ff, pidx_ff)),
      .rd_data (ram_rd_data)
   );

   // pointer and flag update, decided on the accepted beat
   always_comb begin
      full_in    = full_ff;
      wsel_in    = wsel_ff;
      widx_in    = widx_ff;
      psel_in    = psel_ff;
      pidx_in    = pidx_ff;
      s1_meta_in = '{played: 1'b0, status: STATUS_OK, frame_done: 1'b0};

      if (!is_tick) begin
         if (!write_ok) begin
            s1_meta_in.status = STATUS_FULL;
         end else if (widx_ff == LAST_IDX) begin
            // fill half complete, hand it to playback
            widx_in               = '0;
            full_in[wsel_ff]      = 1'b1;
            wsel_in               = !wsel_ff;
            s1_meta_in.frame_done = 1'b1;
         end else begin
            widx_in = widx_ff + 1'b1;
         end
      end else begin
         if (!play_ok) begin
            s1_meta_in.status = STATUS_EMPTY;
         end else begin
            s1_meta_in.played = 1'b1;
            if (pidx_ff == LAST_IDX) begin
               // last sample of the frame, free the half
               pidx_in               = '0;
               full_in[psel_ff]      = 1'b0;
               psel_in               = !psel_ff;
               s1_meta_in.frame_done = 1'b1;
            end else begin
               pidx_in = pidx_ff + 1'b1;
            end
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      rsp_dac_in = s1_meta_ff.played ? dac_code(ram_rd_data) : '0;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff      <= '0;
         wsel_ff      <= 1'b0;
         widx_ff      <= '0;
         psel_ff      <= 1'b0;
         pidx_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            full_ff <= full_in;
            wsel_ff <= wsel_in;
            widx_ff <= widx_in;
            psel_ff <= psel_in;
            pidx_ff <= pidx_in;
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_meta_ff <= s1_meta_in;
      end
      if (s1_adv) begin
         rsp_dac_ff    <= rsp_dac_in;
         rsp_played_ff <= s1_meta_ff.played;
         rsp_status_ff <= s1_meta_ff.status;
         rsp_last_ff   <= s1_meta_ff.frame_done;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(16 - DAC_W)'(0), rsp_dac_ff};
   assign rsp_tuser  = {rsp_status_ff, rsp_played_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire
